/* sv/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 package
// Shared types, round constants and initial values for the hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int WordBits    = 64;
   localparam int BlockWords  = 16;
   localparam int Rounds      = 80;
   localparam int HashWords   = 8;

   typedef logic [WordBits-1:0] word_type;
   typedef logic [3:0]          wpos_type;
   typedef logic [6:0]          round_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   // word sources for the block buffer write
   typedef enum logic [2:0] {
      SRC_DATA,
      SRC_LASTDATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN_HI,
      SRC_LEN_LO
   } src_type;

   typedef struct packed {
      logic      put;        // write a word into the block buffer
      src_type   src;
      logic      add_len;    // add byte count to message length
      logic [3:0] add_bytes;
      logic      init_rounds;
      logic      round;      // run one round
      logic      update;     // fold working vars into hash words
      logic      restart;    // reload initial values, clear length
      logic      emit;       // present digest word
      logic [2:0] emit_idx;
      logic      emit_last;
   } cmd_type;

   typedef struct packed {
      wpos_type  wpos;
      round_type rnd;
   } status_type;

   localparam word_type RK [Rounds] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam word_type IV512 [HashWords] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };
   localparam word_type IV384 [HashWords] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

endpackage

/* sv/sha_datapath.sv */
// ----------------------------------------------------------------------------
// SHA datapath
// Block buffer as a 16-word schedule window, round registers, hash words,
// 128-bit length counter and digest output register.
// ----------------------------------------------------------------------------
module sha_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                mode,
   input  sha_pkg::word_type   in_data,
   input  logic [3:0]          in_count,
   input  sha_pkg::cmd_type    cmd,
   output sha_pkg::status_type status,
   output sha_pkg::word_type   out_word
);
   import sha_pkg::*;

   word_type  w_ff [BlockWords];
   word_type  w_in [BlockWords];
   word_type  v_ff [HashWords];
   word_type  v_in [HashWords];
   word_type  h_ff [HashWords];
   word_type  h_in [HashWords];
   logic [127:0] len_ff, len_in;
   wpos_type  wpos_ff, wpos_in;
   round_type rnd_ff, rnd_in;
   word_type  dig_ff, dig_in;

   word_type  put_word, keep, s0, s1, wnext, t1, t2, e, a;
   logic [127:0] bits;
   logic [6:0] sh;

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (WordBits - n));
   endfunction

   always_comb begin
      sh   = 7'(8 * in_count);
      keep = (in_count == 4'd0) ? '0 : ~(64'hffffffffffffffff >> sh);
      bits = len_ff << 3;
      case (cmd.src)
         SRC_DATA:     put_word = in_data;
         SRC_LASTDATA: put_word = (in_data & keep) | (64'h8000000000000000 >> sh);
         SRC_MARK:     put_word = 64'h8000000000000000;
         SRC_LEN_HI:   put_word = bits[127:64];
         SRC_LEN_LO:   put_word = bits[63:0];
         default:      put_word = '0;
      endcase
   end

   // message schedule and round functions on the rolling window
   always_comb begin
      s0 = rotr(w_ff[1], 1) ^ rotr(w_ff[1], 8) ^ (w_ff[1] >> 7);
      s1 = rotr(w_ff[14], 19) ^ rotr(w_ff[14], 61) ^ (w_ff[14] >> 6);
      wnext = s1 + w_ff[9] + s0 + w_ff[0];
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + RK[rnd_ff] + w_ff[0];
      t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      w_in    = w_ff;
      v_in    = v_ff;
      h_in    = h_ff;
      len_in  = len_ff;
      wpos_in = wpos_ff;
      rnd_in  = rnd_ff;
      dig_in  = dig_ff;
      if (cmd.put) begin
         w_in[wpos_ff] = put_word;
         wpos_in = wpos_ff + 4'd1;
      end
      if (cmd.add_len) len_in = len_ff + 128'(cmd.add_bytes);
      if (cmd.init_rounds) begin
         v_in   = h_ff;
         rnd_in = '0;
      end
      if (cmd.round) begin
         for (int i = 0; i < BlockWords - 1; i++) w_in[i] = w_ff[i+1];
         w_in[BlockWords-1] = wnext;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         rnd_in  = rnd_ff + 7'd1;
      end
      if (cmd.update) begin
         for (int i = 0; i < HashWords; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
      if (cmd.emit) dig_in = h_ff[cmd.emit_idx];
      if (cmd.restart) begin
         h_in    = mode ? IV384 : IV512;
         len_in  = '0;
         wpos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      dig_ff <= dig_in;
      if (reset) begin
         v_ff    <= '{default: '0};
         h_ff    <= IV512;
         len_ff  <= '0;
         wpos_ff <= '0;
         rnd_ff  <= '0;
      end else begin
         v_ff    <= v_in;
         h_ff    <= h_in;
         len_ff  <= len_in;
         wpos_ff <= wpos_in;
         rnd_ff  <= rnd_in;
      end
   end

   assign status.wpos = wpos_ff;
   assign status.rnd  = rnd_ff;
   assign out_word    = dig_ff;

endmodule

/* sv/sha_control.sv */
// ----------------------------------------------------------------------------
// SHA controller
// Sequences word intake, padding, the 80 rounds and digest emission.
// ----------------------------------------------------------------------------
module sha_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                mode,
   input  logic                csr_we,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [3:0]          in_count,
   input  logic                in_last,
   input  sha_pkg::status_type status,
   output sha_pkg::cmd_type    cmd,
   output logic                out_valid,
   output logic                out_last,
   input  logic                out_ready
);
   import sha_pkg::*;

   state_type state_ff, state_in;
   logic      pad_ff, pad_in;       // padding in progress
   logic      mark_ff, mark_in;     // 0x80 still owed as its own word
   logic      hi_ff, hi_in;         // upper length word already in this block
   logic      fin_ff, fin_in;       // last block filled, emit after it is compressed
   logic      ov_ff, ov_in;         // output register holds a word
   logic      lastf_ff, lastf_in;
   logic [2:0] idx_ff, idx_in;
   logic [3:0] cnt;
   logic       fire;

   always_comb begin
      cnt = (in_count > 4'd8) ? 4'd8 : in_count;
      cmd = '0;
      cmd.src = SRC_ZERO;
      state_in = state_ff;
      pad_in = pad_ff;
      mark_in = mark_ff;
      hi_in = hi_ff;
      fin_in = fin_ff;
      idx_in = idx_ff;
      ov_in = ov_ff;
      lastf_in = lastf_ff;
      in_ready = 1'b0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.put = 1'b1;
               cmd.add_len = 1'b1;
               if (!in_last) begin
                  cmd.src = SRC_DATA;
                  cmd.add_bytes = 4'd8;
                  if (status.wpos == 4'd15) state_in = ST_COMPRESS;
               end else begin
                  cmd.add_bytes = cnt;
                  cmd.src = (cnt == 4'd8) ? SRC_DATA : SRC_LASTDATA;
                  mark_in = (cnt == 4'd8);
                  pad_in = 1'b1;
                  state_in = (status.wpos == 4'd15) ? ST_COMPRESS : ST_PAD;
               end
               if (state_in == ST_COMPRESS) cmd.init_rounds = 1'b1;
            end
         end
         ST_PAD: begin
            cmd.put = 1'b1;
            if (mark_ff) begin
               cmd.src = SRC_MARK;
               mark_in = 1'b0;
            end else if (status.wpos == 4'd14) begin
               cmd.src = SRC_LEN_HI;
               hi_in = 1'b1;
            end else if (status.wpos == 4'd15 && hi_ff) begin
               cmd.src = SRC_LEN_LO;
               hi_in = 1'b0;
               fin_in = 1'b1;
               pad_in = 1'b0;
            end else begin
               // zero-fill; a marker past slot 13 pushes the length into another block
               cmd.src = SRC_ZERO;
            end
            if (status.wpos == 4'd15) begin
               cmd.init_rounds = 1'b1;
               state_in = ST_COMPRESS;
            end
         end
         ST_COMPRESS: begin
            cmd.round = 1'b1;
            if (status.rnd == 7'(Rounds - 1)) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            idx_in = '0;
            if (fin_ff) state_in = ST_EMIT;
            else if (pad_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (!ov_ff || out_ready) begin
               cmd.emit = 1'b1;
               cmd.emit_idx = idx_ff;
               ov_in = 1'b1;
               lastf_in = (idx_ff == (mode ? 3'd5 : 3'd7));
               idx_in = idx_ff + 3'd1;
               if (lastf_in) begin
                  cmd.restart = 1'b1;
                  fin_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      fire = 1'b0;
      if (csr_we) begin
         cmd = '0;
         cmd.src = SRC_ZERO;
         cmd.restart = 1'b1;
         state_in = ST_IDLE;
         pad_in = 1'b0;
         mark_in = 1'b0;
         hi_in = 1'b0;
         fin_in = 1'b0;
         fire = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         hi_ff    <= 1'b0;
         fin_ff   <= 1'b0;
         ov_ff    <= 1'b0;
         lastf_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         hi_ff    <= hi_in;
         fin_ff   <= fin_in;
         ov_ff    <= fire ? ov_in : ov_in;
         lastf_ff <= lastf_in;
         idx_ff   <= idx_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_last  = lastf_ff;

endmodule

/* sv/sha512_sha384_hash_engine.sv */
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hash engine
// Top level: mode register, controller and datapath.
// ----------------------------------------------------------------------------
// A request carries one 64-bit big-endian message word; tlast marks the final
// word and tuser gives its valid byte count (0..8, above 8 counts as 8). A
// word that fills a 16-word block holds the input while the block is
// compressed (80 rounds on the single round unit plus a fold); other words
// are accepted one per cycle. After the last word the engine writes the
// padding words and runs one or two compressions, then 8 (SHA-512) or 6
// (SHA-384) digest words leave on rsp, one per cycle when taken. A csr write
// selects the mode (1 = SHA-384) and restarts the message.
module sha512_sha384_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,       // hash_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,       // data_word
   input  logic [3:0]  req_tuser,       // byte_count
   input  logic        req_tlast,       // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,       // digest_word
   output logic        rsp_tlast        // digest_last
);
   import sha_pkg::*;

   logic       mode_ff, mode_in;
   cmd_type    cmd;
   status_type status;

   assign mode_in = csr_we ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else       mode_ff <= mode_in;
   end

   sha_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_in),
      .csr_we    (csr_we),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_count  (req_tuser),
      .in_last   (req_tlast),
      .status    (status),
      .cmd       (cmd),
      .out_valid (rsp_tvalid),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

   sha_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_in),
      .in_data  (req_tdata),
      .in_count ((req_tuser > 4'd8) ? 4'd8 : req_tuser),
      .cmd      (cmd),
      .status   (status),
      .out_word (rsp_tdata)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hash engine testbench
// Streams message words through the engine in both modes and checks every
// digest word against an in-bench SHA-512/SHA-384 predictor with random flow control.
// ----------------------------------------------------------------------------
module testbench;
   import sha_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   typedef struct packed {
      logic [63:0] word;
      logic        last;
   } digest_item_type;

   digest_item_type digest_queue[$];
   int  fail_count = 0;
   int  digest_count = 0;
   int  message_count = 0;
   int  request_count = 0;
   longint unsigned cycle_count = 0;
   bit  hold_off = 1'b0;
   bit  burst_mode = 1'b1;

   // predictor state
   logic        mode_384 = 1'b0;
   word_type    hash_state [HashWords];
   word_type    block_buf [BlockWords];
   int          fill_pos;
   logic [127:0] byte_total;

   sha512_sha384_hash_engine i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("sha512_sha384_hash_engine: mismatch");
         $finish;
      end
   end

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < HashWords; i++)
         hash_state[i] = mode_384 ? IV384[i] : IV512[i];
      fill_pos = 0;
      byte_total = '0;
   endtask

   task automatic compress_block();
      word_type sched [Rounds];
      word_type v [HashWords];
      word_type t1, t2, s0, s1;
      for (int i = 0; i < Rounds; i++) begin
         if (i < BlockWords) begin
            sched[i] = block_buf[i];
         end else begin
            s0 = rotr(sched[i-15], 1) ^ rotr(sched[i-15], 8) ^ (sched[i-15] >> 7);
            s1 = rotr(sched[i-2], 19) ^ rotr(sched[i-2], 61) ^ (sched[i-2] >> 6);
            sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
         end
      end
      for (int i = 0; i < HashWords; i++) v[i] = hash_state[i];
      for (int r = 0; r < Rounds; r++) begin
         t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + sched[r];
         t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int k = 7; k > 0; k--) v[k] = v[k-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < HashWords; i++) hash_state[i] += v[i];
   endtask

   task automatic append_word(word_type w);
      block_buf[fill_pos] = w;
      fill_pos++;
      if (fill_pos == BlockWords) begin
         compress_block();
         fill_pos = 0;
      end
   endtask

   // absorb one accepted request; queue the digest on the last word
   task automatic predict_request(word_type data, logic [3:0] count, logic last);
      int nbytes;
      int nout;
      word_type keep;
      if (!last) begin
         byte_total += 128'd8;
         append_word(data);
         return;
      end
      nbytes = (count > 8) ? 8 : count;
      byte_total += nbytes;
      if (nbytes == 8) begin
         append_word(data);
         append_word(64'h80 << 56);
      end else begin
         keep = (nbytes == 0) ? '0 : ~64'd0 << (64 - 8 * nbytes);
         append_word((data & keep) | (64'h80 << (56 - 8 * nbytes)));
      end
      if (fill_pos > BlockWords - 2)
         while (fill_pos != 0) append_word('0);
      while (fill_pos < BlockWords - 2) append_word('0);
      append_word(byte_total[124:61]);
      append_word({byte_total[60:0], 3'b000});
      nout = mode_384 ? 6 : 8;
      for (int i = 0; i < nout; i++)
         digest_queue.push_back('{word: hash_state[i], last: (i == nout - 1)});
      message_count++;
      restart_hash();
   endtask

   task automatic send_request(word_type data, logic [3:0] count, logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= count;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_request(data, count, last);
      request_count++;
      // gap after the request: random gaps in burst mode, else a gap after every request
      if (burst_mode && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end else if (!burst_mode) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
      mode_384 = m;
      restart_hash();
   endtask

   task automatic send_message(int nwords, logic [3:0] count);
      for (int i = 0; i < nwords - 1; i++)
         send_request({$urandom, $urandom}, 4'($urandom), 1'b0);
      send_request({$urandom, $urandom}, count, 1'b1);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            $error("unexpected digest word %h", rsp_tdata);
            fail_count++;
         end else begin
            digest_item_type exp_item;
            exp_item = digest_queue.pop_front();
            if (rsp_tdata !== exp_item.word) begin
               $error("digest_word expected %h actual %h", exp_item.word, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== exp_item.last) begin
               $error("digest_last expected %b actual %b", exp_item.last, rsp_tlast);
               fail_count++;
            end
            digest_count++;
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || cycle_count[9];
   end

   task automatic test_directed_sha512();
      write_mode(1'b0);
      send_request(64'h6162638000000000, 4'd3, 1'b1);   // "abc"
      send_request('0, 4'd0, 1'b1);                      // empty message
      send_request(64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1);    // full last word
      send_request(64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1);   // count saturates
      send_request(64'h0123456789ABCDEF, 4'd0, 1'b1);    // zero count drops data
      send_message(14, 4'd8);                            // extra padding block
      send_message(14, 4'd7);
      send_message(15, 4'd0);
      send_message(16, 4'd8);
      drain_and_settle();
   endtask

   task automatic test_directed_sha384();
      write_mode(1'b1);
      send_request(64'h0000000000000000, 4'd1, 1'b1);
      send_request(64'hFFFFFFFFFFFFFFFF, 4'd9, 1'b0);   // count ignored mid-message
      send_request(64'hA5A5A5A5A5A5A5A5, 4'd5, 1'b1);
      drain_and_settle();
   endtask

   task automatic test_abandoned_message();
      send_message(5, 4'd4);
      send_request({$urandom, $urandom}, 4'd8, 1'b0);  // left unfinished
      drain_and_settle();
      write_mode(1'b0);
      send_message(3, 4'd2);
      drain_and_settle();
   endtask

   task automatic test_receiver_hold_off();
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int m = 0; m < 4; m++) send_message(1, 4'($urandom_range(0, 8)));
      join
      drain_and_settle();
   endtask

   task automatic test_random_messages(logic m, int nitems);
      int sent;
      sent = 0;
      write_mode(m);
      while (sent < nitems) begin
         int len;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 6);
         burst_mode = ($urandom_range(0, 3) != 0);
         send_message(len, 4'($urandom));
         sent += len;
      end
      burst_mode = 1'b1;
      drain_and_settle();
   endtask

   initial begin
      restart_hash();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_sha512();
      test_directed_sha384();
      test_abandoned_message();
      test_receiver_hold_off();
      test_random_messages(1'b0, 70);
      test_random_messages(1'b1, 70);
      if (digest_queue.size() != 0) begin
         $error("%0d digest words never arrived", digest_queue.size());
         fail_count++;
      end
      $display("Covered %0d requests, %0d messages, %0d digest words in both modes.",
               request_count, message_count, digest_count);
      if (fail_count == 0) begin
         $display("sha512_sha384_hash_engine: match");
      end else begin
         $display("sha512_sha384_hash_engine: mismatch");
      end
      $finish;
   end

endmodule

/* sha512_sha384_hash_engine.f */
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_control.sv
sv/sha512_sha384_hash_engine.sv
tb/sv/testbench.sv
